/* hw/rtl/srsd_pkg.sv */
`timescale 1ns / 1ps

package srsd_pkg;

  localparam int DEF_MAX_WINDOW   = 64;
  localparam int DEF_PENALTY_BITS = 32;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 10;
  localparam int WLEN_REG_W = 7;
  localparam int LIMIT_W    = 10;

  localparam int RST_WINDOW_LENGTH = 16;
  localparam int RST_STAT_LIMIT    = 172;

  // result item
  localparam int RSUM_W      = 14;
  localparam int OUT_TDATA_W = 16;

  // (S - m)^2 * 12 * 2^14 == (S - m)^2 * 3 * 2^16
  localparam int STAT_SCALE_MUL   = 3;
  localparam int STAT_SCALE_SHIFT = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_LENGTH = 1'b0,
    REG_STAT_LIMIT    = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN,
    ST_UPDATE,
    ST_DEV,
    ST_GO,
    ST_WAIT,
    ST_OUT
  } state_e;

  typedef enum logic [1:0] {
    RD_Y,
    RD_Z,
    RD_W
  } rd_kind_e;

endpackage

/* hw/rtl/sliding_rank_sum_change_detector.sv */
`timescale 1ns / 1ps

// Sliding rank-sum change detector.
// Input stream (s_axis_*): one penalty item per transfer. Output stream (m_axis_*): one result
// item per input item, windows_differ in bit 0 and rank_sum_x2 in bits 14:1.
// Config port: cfg_we_i writes register cfg_idx_i (0 window_length, 1 stat_limit_q8) with
// cfg_data_i; write only while the block is idle. Writing window_length empties both windows.
// Ranks are kept incrementally: a cross-window pair score is updated per item by one walk
// over the 2*L stored samples (L = window length) in the sample RAM, preceded by two reads
// that fetch the samples leaving the recent and the older window. One RAM read per cycle
// sets the rate of the walk, and the next item is accepted only after the result of the
// last one is loaded into the output register.
// Reset: window_length 16, stat_limit_q8 172, both windows read as all-ones samples; a fill
// count stands in for clearing the RAM, so no clearing pass is needed.
// Stalls: the result sits in an output register; a new item is accepted and processed while
// it waits, and the block holds the next result until the register is free.
module sliding_rank_sum_change_detector
  import srsd_pkg::*;
#(
  parameter int MAX_WINDOW   = DEF_MAX_WINDOW,
  parameter int PENALTY_BITS = DEF_PENALTY_BITS,
  localparam int IN_TDATA_W  = ((PENALTY_BITS + 7) / 8) * 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [PENALTY_BITS-1:0] penalty
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [0] windows_differ, [14:1] rank_sum_x2
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int DEPTH   = 2 * MAX_WINDOW;
  localparam int AW      = $clog2(DEPTH);
  localparam int NW      = $clog2(DEPTH + 1);
  localparam int JW      = $clog2(DEPTH + 2);
  localparam int LW      = $clog2(MAX_WINDOW + 1);
  localparam int LSQW    = $clog2(MAX_WINDOW * MAX_WINDOW + 1);
  localparam int DW      = $clog2(2 * MAX_WINDOW * MAX_WINDOW + 1);
  localparam int SUMW    = DW + 1;
  localparam int ACCW    = $clog2(4 * MAX_WINDOW + 1) + 1;
  localparam int RST_LEN = (RST_WINDOW_LENGTH > MAX_WINDOW) ? MAX_WINDOW : RST_WINDOW_LENGTH;

  state_e state_q, state_d;

  logic [LW-1:0]           len_q;
  logic [LSQW-1:0]         len_sq_q;
  logic [LIMIT_W-1:0]      limit_q;
  logic [AW-1:0]           head_q;
  logic [NW-1:0]           fill_q;
  logic [DW-1:0]           dsum_q;
  logic [PENALTY_BITS-1:0] x_q, y_q, z_q;
  logic [JW-1:0]           iss_q;
  logic                    tag_vld_q;
  rd_kind_e                tag_kind_q;
  logic [AW-1:0]           tag_k_q;
  logic signed [ACCW-1:0]  acc_q;
  logic [RSUM_W-1:0]       rsum_q;
  logic [DW-1:0]           dev_q;
  logic                    m_tvalid_q;
  logic [OUT_TDATA_W-1:0]  m_tdata_q;

  logic                    s_acc;
  logic                    out_free;
  logic                    iss_last;
  rd_kind_e                iss_kind;
  logic [AW-1:0]           iss_k;
  logic [AW-1:0]           rd_addr;
  logic [PENALTY_BITS-1:0] rd_data;
  logic [PENALTY_BITS-1:0] w;
  logic signed [3:0]       delta;
  logic [LW-1:0]           cfg_len;
  logic [SUMW-1:0]         sum_full;
  logic                    stat_done;
  logic                    stat_differ;

  // position of the sample written k items before the newest one
  function automatic logic [AW-1:0] ring_pos(input logic [AW-1:0] head,
                                             input logic [AW-1:0] k);
    logic [AW:0] t;
    t = {1'b0, head} + (AW+1)'(DEPTH - 1) - {1'b0, k};
    if (t >= (AW+1)'(DEPTH)) begin
      t = t - (AW+1)'(DEPTH);
    end
    return t[AW-1:0];
  endfunction

  assign s_acc    = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_tvalid_q || m_axis_tready;
  assign iss_last = (32'(iss_q) == 2 * 32'(len_q) + 1);

  // read order: sample leaving the recent window, sample leaving the older one, then all 2L
  always_comb begin
    if (iss_q == JW'(0)) begin
      iss_kind = RD_Y;
      iss_k    = AW'(32'(len_q) - 1);
    end else if (iss_q == JW'(1)) begin
      iss_kind = RD_Z;
      iss_k    = AW'(2 * 32'(len_q) - 1);
    end else begin
      iss_kind = RD_W;
      iss_k    = AW'(32'(iss_q) - 2);
    end
    rd_addr = ring_pos(head_q, iss_k);
  end

  srsd_ram #(
    .WIDTH(PENALTY_BITS),
    .DEPTH(DEPTH)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (state_q == ST_UPDATE),
    .waddr_i(head_q),
    .wdata_i(x_q),
    .re_i   (state_q == ST_ISSUE),
    .raddr_i(rd_addr),
    .rdata_o(rd_data)
  );

  // slots not written since the last refill hold the all-ones sample
  assign w = (32'(tag_k_q) < 32'(fill_q)) ? rd_data : '1;

  // change of the cross-window pair score contributed by the sample at tag_k_q
  always_comb begin
    logic [1:0] c_zw, c_wy, c_wx, c_yx;
    int unsigned kk, ll;
    c_zw  = {z_q < w, z_q == w};
    c_wy  = {w < y_q, w == y_q};
    c_wx  = {w < x_q, w == x_q};
    c_yx  = {y_q < x_q, y_q == x_q};
    kk    = 32'(tag_k_q);
    ll    = 32'(len_q);
    delta = '0;
    if (kk < ll) begin
      delta = delta - $signed({2'b00, c_zw});
    end
    if (kk + 1 < ll) begin
      delta = delta + 4'sd2 - $signed({2'b00, c_wy});
    end
    if (kk + 1 == ll) begin
      delta = delta + $signed({2'b00, c_yx});
    end
    if (kk >= ll && kk + 2 <= 2 * ll) begin
      delta = delta + $signed({2'b00, c_wx}) - $signed({2'b00, c_wy});
    end
  end

  always_comb begin
    if (cfg_data_i[WLEN_REG_W-1:0] == '0) begin
      cfg_len = LW'(1);
    end else if (32'(cfg_data_i[WLEN_REG_W-1:0]) > 32'(MAX_WINDOW)) begin
      cfg_len = LW'(MAX_WINDOW);
    end else begin
      cfg_len = LW'(cfg_data_i[WLEN_REG_W-1:0]);
    end
  end

  assign sum_full = SUMW'(len_sq_q) + SUMW'(len_q) + SUMW'(dsum_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (s_acc) state_d = ST_ISSUE;
      ST_ISSUE:  if (iss_last) state_d = ST_DRAIN;
      ST_DRAIN:  state_d = ST_UPDATE;
      ST_UPDATE: state_d = ST_DEV;
      ST_DEV:    state_d = ST_GO;
      ST_GO:     state_d = ST_WAIT;
      ST_WAIT:   if (stat_done) state_d = ST_OUT;
      ST_OUT:    if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q      <= LW'(RST_LEN);
      len_sq_q   <= LSQW'(RST_LEN * RST_LEN);
      limit_q    <= LIMIT_W'(RST_STAT_LIMIT);
      head_q     <= '0;
      fill_q     <= '0;
      dsum_q     <= DW'(RST_LEN * RST_LEN);
      iss_q      <= '0;
      tag_vld_q  <= 1'b0;
      m_tvalid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_reg_e'(cfg_idx_i))
          REG_WINDOW_LENGTH: begin
            len_q    <= cfg_len;
            len_sq_q <= LSQW'(LSQW'(cfg_len) * LSQW'(cfg_len));
            dsum_q   <= DW'(DW'(cfg_len) * DW'(cfg_len));
            head_q   <= '0;
            fill_q   <= '0;
          end
          REG_STAT_LIMIT: limit_q <= cfg_data_i[LIMIT_W-1:0];
        endcase
      end
      if (s_acc) begin
        iss_q <= '0;
      end else if (state_q == ST_ISSUE) begin
        iss_q <= iss_q + JW'(1);
      end
      tag_vld_q <= (state_q == ST_ISSUE);
      if (state_q == ST_UPDATE) begin
        head_q <= (head_q == AW'(DEPTH - 1)) ? '0 : head_q + AW'(1);
        if (fill_q != NW'(DEPTH)) begin
          fill_q <= fill_q + NW'(1);
        end
        dsum_q <= DW'($signed({1'b0, dsum_q}) + (DW+1)'(acc_q));
      end
      if (state_q == ST_OUT && out_free) begin
        m_tvalid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_tvalid_q <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      x_q   <= s_axis_tdata[PENALTY_BITS-1:0];
      acc_q <= '0;
    end else if (tag_vld_q && tag_kind_q == RD_W) begin
      acc_q <= acc_q + ACCW'(delta);
    end
    if (tag_vld_q && tag_kind_q == RD_Y) begin
      y_q <= w;
    end
    if (tag_vld_q && tag_kind_q == RD_Z) begin
      z_q <= w;
    end
    tag_kind_q <= iss_kind;
    tag_k_q    <= iss_k;
    if (state_q == ST_DEV) begin
      // |S - L(2L+1)| reduces to |pair score - L^2|
      dev_q  <= (dsum_q >= DW'(len_sq_q)) ? dsum_q - DW'(len_sq_q) : DW'(len_sq_q) - dsum_q;
      rsum_q <= RSUM_W'(sum_full);
    end
    if (state_q == ST_OUT && out_free) begin
      m_tdata_q <= OUT_TDATA_W'({rsum_q, stat_differ});
    end
  end

  srsd_stat #(
    .MAX_WINDOW(MAX_WINDOW)
  ) u_stat (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == ST_GO),
    .dev_i   (dev_q),
    .len_i   (len_q),
    .len_sq_i(len_sq_q),
    .limit_i (limit_q),
    .done_o  (stat_done),
    .differ_o(stat_differ)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata  = m_tdata_q;

  a_score_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> 32'(dsum_q) <= 2 * 32'(len_sq_q))
    else $error("pair score exceeds 2*L^2");

  a_tag_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tag_vld_q |-> (state_q == ST_ISSUE || state_q == ST_DRAIN))
    else $error("read data returned outside the walk");

  a_stat_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_GO |-> ##3 stat_done)
    else $error("statistic result late");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_UPDATE |=> 32'(fill_q) <= DEPTH && 32'(head_q) < DEPTH)
    else $error("ring pointer out of range");

endmodule

/* hw/rtl/srsd_ram.sv */
`timescale 1ns / 1ps

module srsd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/srsd_stat.sv */
`timescale 1ns / 1ps

// Three-stage squared test: (dev^2 * 3) << 16 > limit^2 * len^2 * (2 len + 1).
module srsd_stat
  import srsd_pkg::*;
#(
  parameter int MAX_WINDOW = DEF_MAX_WINDOW,
  localparam int LW   = $clog2(MAX_WINDOW + 1),
  localparam int LSQW = $clog2(MAX_WINDOW * MAX_WINDOW + 1),
  localparam int DW   = $clog2(2 * MAX_WINDOW * MAX_WINDOW + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [DW-1:0]      dev_i,
  input  logic [LW-1:0]      len_i,
  input  logic [LSQW-1:0]    len_sq_i,
  input  logic [LIMIT_W-1:0] limit_i,
  output logic               done_o,
  output logic               differ_o
);

  localparam int SQW = 2 * DW;
  localparam int LMW = 2 * LIMIT_W;
  localparam int VW  = LSQW + LW + 1;
  localparam int LHW = SQW + 2 + STAT_SCALE_SHIFT;
  localparam int RHW = LMW + VW;
  localparam int CW  = (LHW > RHW) ? LHW : RHW;

  logic [2:0]     vld_q;
  logic [SQW-1:0] dsq_q;
  logic [LMW-1:0] lsq_q;
  logic [VW-1:0]  vol_q;
  logic [LHW-1:0] lhs_q;
  logic [RHW-1:0] rhs_q;
  logic           differ_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[1:0], start_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dsq_q <= SQW'(dev_i) * SQW'(dev_i);
      lsq_q <= LMW'(limit_i) * LMW'(limit_i);
      vol_q <= VW'(len_sq_i) * VW'({len_i, 1'b1});
    end
    if (vld_q[0]) begin
      lhs_q <= (LHW'(dsq_q) * LHW'(STAT_SCALE_MUL)) << STAT_SCALE_SHIFT;
      rhs_q <= RHW'(lsq_q) * RHW'(vol_q);
    end
    if (vld_q[1]) begin
      differ_q <= CW'(lhs_q) > CW'(rhs_q);
    end
  end

  assign done_o   = vld_q[2];
  assign differ_o = differ_q;

endmodule
